### sv/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the integer list sorter.
// ----------------------------------------------------------------------------
package ils_pkg;

    // Default sizing of the sorting chain
    localparam int MAX_ELEMENTS = 64;
    localparam int WORD_BITS    = 64;

    // Fixed stream and configuration widths
    localparam int DATA_W      = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 2;
    localparam int ORDER_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SORT_ORDER   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SIGNED = 1'd1;

    // Sort order codes (the unused code behaves as passthrough)
    localparam logic [ORDER_W-1:0] ORDER_PASS = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_ASC  = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_DESC = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_DRAIN
    } state_t;

    // Per-cycle command broadcast along the chain
    typedef struct packed {
        logic load;       // store the request word in the cell at the fill count
        logic sort;       // perform one odd-even transposition pass
        logic shift;      // move every word one cell towards the output
        logic parity;     // pass parity: pairs start on even (0) or odd (1) cells
        logic descending; // larger keys go first
        logic signed_cmp; // compare as two's complement
    } cell_ctrl_t;

endpackage

### sv/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// One storage cell of the sorting chain: holds a word, compares it with its
// upper neighbour when it leads a pair, and takes part in load and shift.
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int WORD_BITS = ils_pkg::WORD_BITS,
    parameter int CNT_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                  clk,
    input  ils_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [WORD_BITS-1:0]  load_val,
    input  logic [WORD_BITS-1:0]  up_val,
    input  logic [WORD_BITS-1:0]  dn_val,
    input  logic                  dn_swap,
    output logic [WORD_BITS-1:0]  val,
    output logic                  swap
);

    localparam logic             IDX_ODD  = 1'(INDEX % 2);
    localparam logic [CNT_W-1:0] IDX_SELF = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

    logic [WORD_BITS-1:0] val_reg;
    logic [WORD_BITS-1:0] val_next;
    logic [WORD_BITS-1:0] flip;
    logic [WORD_BITS-1:0] key_self;
    logic [WORD_BITS-1:0] key_up;
    logic                 pair_lo;
    logic                 up_first;

    // Signed order: flip the sign bit so an unsigned compare gives the answer
    assign flip     = {ctrl.signed_cmp, {(WORD_BITS-1){1'b0}}};
    assign key_self = val_reg ^ flip;
    assign key_up   = up_val ^ flip;

    // This cell leads a pair when the parity matches and both words are live
    assign pair_lo  = (IDX_ODD == ctrl.parity) && (IDX_NEXT < count);
    assign up_first = ctrl.descending ? (key_up > key_self) : (key_up < key_self);
    assign swap     = ctrl.sort && pair_lo && up_first;

    // Next value
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.load && (count == IDX_SELF))
        begin
            val_next = load_val;
        end
        else if (ctrl.shift)
        begin
            val_next = up_val;
        end
        else if (swap)
        begin
            val_next = up_val;
        end
        else if (ctrl.sort && dn_swap)
        begin
            val_next = dn_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

### sv/integer_list_sorter.sv
// ----------------------------------------------------------------------------
// integer_list_sorter
// Collects a list of words and returns it ascending, descending or in arrival
// order, using a chain of compare-exchange cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_tvalid/s_tready/s_tdata with s_tlast marking
//   the final word of a list. Only the low WORD_BITS bits of a word are kept.
//   Up to MAX_ELEMENTS words are held; later words are discarded and the final
//   output request carries m_tuser = 1 to report the loss.
//   After the last word the list comes back on m_tvalid/m_tready/m_tdata, one
//   word per request, m_tlast on the final one.
//   Sequence for a list of n stored words: the input words are taken, then n
//   odd-even transposition passes run along the cell chain (skipped for
//   passthrough or a single word), every cell pair comparing in parallel
//   within a pass, and then the list is emitted word by word.
//   s_tready is low while a list is being sorted or emitted.
//   Order and signedness registers are sampled while sorting; write them only
//   between lists. A stalled receiver simply holds the current output word.
//   Reset empties the list, clears the loss flag and selects ascending
//   unsigned order.
// ----------------------------------------------------------------------------
module integer_list_sorter #(
    parameter int MAX_ELEMENTS = ils_pkg::MAX_ELEMENTS,
    parameter int WORD_BITS    = ils_pkg::WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ils_pkg::DATA_W-1:0]    s_tdata,   // [63:0] word
    input  logic                          s_tlast,
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ils_pkg::DATA_W-1:0]    m_tdata,   // [63:0] word_out
    output logic                          m_tlast,
    output logic                          m_tuser,   // [0] dropped
    // Configuration writes
    input  logic                          cfg_we,
    input  logic [ils_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ils_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    ils_pkg::state_t state_reg;
    ils_pkg::state_t state_next;

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             pass_reg;
    logic [CNT_W-1:0]             pass_next;
    logic                         overflow_reg;
    logic                         overflow_next;
    logic [ils_pkg::ORDER_W-1:0]  sort_order_reg;
    logic                         value_signed_reg;

    logic                         in_acc;
    logic                         out_acc;
    logic                         room;
    logic                         sorting;
    logic                         last_pass;
    logic [CNT_W-1:0]             count_after;
    ils_pkg::cell_ctrl_t          ctrl;

    logic [WORD_BITS-1:0]         cell_val  [MAX_ELEMENTS];
    logic                         cell_swap [MAX_ELEMENTS];

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign room      = (count_reg < CNT_MAX);
    assign count_after = room ? (count_reg + CNT_ONE) : count_reg;
    assign sorting   = (sort_order_reg == ils_pkg::ORDER_ASC) ||
                       (sort_order_reg == ils_pkg::ORDER_DESC);
    assign last_pass = (pass_reg == (count_reg - CNT_ONE));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_order_reg   <= ils_pkg::ORDER_ASC;
            value_signed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ils_pkg::CFG_SORT_ORDER:   sort_order_reg   <= cfg_data[ils_pkg::ORDER_W-1:0];
                ils_pkg::CFG_VALUE_SIGNED: value_signed_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ils_pkg::ST_LOAD:
            begin
                if (in_acc && s_tlast)
                begin
                    state_next = (sorting && (count_after > CNT_ONE)) ?
                                 ils_pkg::ST_SORT : ils_pkg::ST_DRAIN;
                end
            end
            ils_pkg::ST_SORT:
            begin
                if (last_pass)
                begin
                    state_next = ils_pkg::ST_DRAIN;
                end
            end
            ils_pkg::ST_DRAIN:
            begin
                if (out_acc && (count_reg == CNT_ONE))
                begin
                    state_next = ils_pkg::ST_LOAD;
                end
            end
            default: state_next = ils_pkg::ST_LOAD;
        endcase
    end

    // Outputs and counters
    always_comb
    begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        count_next      = count_reg;
        pass_next       = pass_reg;
        overflow_next   = overflow_reg;
        ctrl.load       = 1'b0;
        ctrl.sort       = 1'b0;
        ctrl.shift      = 1'b0;
        ctrl.parity     = pass_reg[0];
        ctrl.descending = (sort_order_reg == ils_pkg::ORDER_DESC);
        ctrl.signed_cmp = value_signed_reg;
        case (state_reg)
            ils_pkg::ST_LOAD:
            begin
                s_tready  = 1'b1;
                pass_next = '0;
                if (in_acc)
                begin
                    ctrl.load     = room;
                    count_next    = count_after;
                    overflow_next = overflow_reg || !room;
                end
            end
            ils_pkg::ST_SORT:
            begin
                ctrl.sort = 1'b1;
                pass_next = pass_reg + CNT_ONE;
            end
            ils_pkg::ST_DRAIN:
            begin
                m_tvalid = 1'b1;
                if (out_acc)
                begin
                    ctrl.shift = 1'b1;
                    count_next = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE)
                    begin
                        overflow_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ils_pkg::ST_LOAD;
            count_reg    <= '0;
            pass_reg     <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pass_reg     <= pass_next;
            overflow_reg <= overflow_next;
        end
    end

    // Cell chain: cell 0 faces the output
    for (genvar i = 0; i < MAX_ELEMENTS; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] up_v;
        logic [WORD_BITS-1:0] dn_v;
        logic                 dn_s;

        if (i == MAX_ELEMENTS - 1)
        begin : g_top
            assign up_v = '0;
        end
        else
        begin : g_mid
            assign up_v = cell_val[i+1];
        end

        if (i == 0)
        begin : g_bot
            assign dn_v = '0;
            assign dn_s = 1'b0;
        end
        else
        begin : g_low
            assign dn_v = cell_val[i-1];
            assign dn_s = cell_swap[i-1];
        end

        ils_cell #(
            .WORD_BITS (WORD_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .count    (count_reg),
            .load_val (s_tdata[WORD_BITS-1:0]),
            .up_val   (up_v),
            .dn_val   (dn_v),
            .dn_swap  (dn_s),
            .val      (cell_val[i]),
            .swap     (cell_swap[i])
        );
    end

    // Output request fields
    assign m_tdata = ils_pkg::DATA_W'(cell_val[0]);
    assign m_tlast = (count_reg == CNT_ONE);
    assign m_tuser = overflow_reg && (count_reg == CNT_ONE);

    // Checks
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (count_reg != '0))
        else $error("output offered with an empty list");

    a_drop_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tuser |-> m_tlast)
        else $error("loss flag on a non-final word");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ils_pkg::ST_SORT) |-> (pass_reg < count_reg))
        else $error("sort pass beyond list length");

    a_list_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_tlast) |=> ((count_reg == '0) && !overflow_reg))
        else $error("list state not cleared after final word");

    a_overflow_set: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (count_reg == CNT_MAX)) |=> overflow_reg)
        else $error("discarded word not recorded");

endmodule
